FILE: rtl/bsr22_pkg.sv
// Shared types, constants and an index helper for the 2x2 block sparse
// matrix-vector accumulator. No dependencies.
`timescale 1ns / 1ps

package bsr22_pkg;

    // Store geometry: elements are kept as even/odd pairs, one bank each.
    localparam int STORE_DEPTH = 1024;
    localparam int BLOCK_DIM   = 2;
    localparam int PAIR_DEPTH  = STORE_DEPTH / BLOCK_DIM;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PAIR_W      = $clog2(PAIR_DEPTH);

    // Field widths.
    localparam int VAL_W  = 8;
    localparam int WORD_W = 32;
    localparam int CFG_W  = 2;

    // Matrix bounds in blocks.
    localparam int MAX_BLOCK_COLS = 512;
    localparam int MAX_BLOCK_ROWS = 512;
    localparam int LIMIT_W        = 17;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_BLOCK  = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef enum logic [CFG_W-1:0] {
        CFG_ALPHA      = 2'd0,
        CFG_BETA       = 2'd1,
        CFG_DIRECTION  = 2'd2,
        CFG_INDEX_BASE = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic              ok;
        logic [PAIR_W-1:0] pair;
    } t_pair_chk;

    // Removes the index base and checks the block index against its limit
    // and against the pair capacity of the stores.
    function automatic t_pair_chk pair_check(input logic [IDX_W-1:0] raw,
                                             input logic             base,
                                             input int               limit);
        logic [IDX_W-1:0] idx;
        logic             neg;
        t_pair_chk        res;
        idx      = raw - IDX_W'(base);
        neg      = base && (raw == '0);
        res.ok   = !neg && (LIMIT_W'(idx) < LIMIT_W'(limit))
                   && (LIMIT_W'(idx) < LIMIT_W'(PAIR_DEPTH));
        res.pair = idx[PAIR_W-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/bsr22_ifs.sv
// Valid/ready channel interfaces: configuration writes, input items and
// result beats. Depends on bsr22_pkg for field widths.
`timescale 1ns / 1ps

interface bsr22_cfg_if;
    import bsr22_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  index;
    logic [WORD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bsr22_in_if;
    import bsr22_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic [IDX_W-1:0]         element_index;
    logic signed [WORD_W-1:0] load_value;
    logic [IDX_W-1:0]         block_row;
    logic [IDX_W-1:0]         block_col;
    logic signed [VAL_W-1:0]  val0;
    logic signed [VAL_W-1:0]  val1;
    logic signed [VAL_W-1:0]  val2;
    logic signed [VAL_W-1:0]  val3;
    logic                     row_last;

    modport source (output valid, output operation, output element_index,
                    output load_value, output block_row, output block_col,
                    output val0, output val1, output val2, output val3,
                    output row_last, input ready);
    modport sink   (input valid, input operation, input element_index,
                    input load_value, input block_row, input block_col,
                    input val0, input val1, input val2, input val3,
                    input row_last, output ready);
endinterface

interface bsr22_out_if;
    import bsr22_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         y_index;
    logic signed [WORD_W-1:0] y_value;
    logic                     last;

    modport source (output valid, output y_index, output y_value, output last,
                    input ready);
    modport sink   (input valid, input y_index, input y_value, input last,
                    output ready);
endinterface

FILE: rtl/bsr22_spmv_top.sv
// Top level of the 2x2 block sparse matrix-vector accumulator: config
// registers, three-stage datapath and banked x/y stores.
// Depends on bsr22_pkg, bsr22_ifs and bsr22_ram.
`timescale 1ns / 1ps

// Channel   Dir  Beat carries
// i_cfg     in   register index, 32-bit write data (always ready)
// i_in      in   operation, load fields, block indices, four values, row_last
// o_out     out  y_index, y_value, last (two beats per row end that writes y)
//
// One item is accepted per cycle unless a hazard or a held pipeline stalls input;
// a row end passes the pipeline stages and the output register and, if it writes y,
// leaves as two beats, so the output port sets the pace of back-to-back row ends.
// y is read at accept, so a row end waits while an item ahead still writes its pair.
// Reset is synchronous and clears control state only; the stores are not cleared.
// A stalled output holds the pipeline once a y-writing row end reaches the last stage.

module bsr_2x2_spmv_accumulator_top (
    input  logic i_clk,
    input  logic i_rst_n,
    bsr22_cfg_if.sink   i_cfg,
    bsr22_in_if.sink    i_in,
    bsr22_out_if.source o_out
);
    import bsr22_pkg::*;

    // Configuration registers.
    logic [WORD_W-1:0] r_alpha;
    logic [WORD_W-1:0] r_beta;
    logic              r_direction;
    logic              r_index_base;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= WORD_W'(1);
            r_beta       <= '0;
            r_direction  <= 1'b0;
            r_index_base <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_ALPHA:      r_alpha      <= i_cfg.data;
                CFG_BETA:       r_beta       <= i_cfg.data;
                CFG_DIRECTION:  r_direction  <= i_cfg.data[0];
                CFG_INDEX_BASE: r_index_base <= i_cfg.data[0];
            endcase
        end
    end

    // Pipeline registers.
    logic                        r_v1;
    t_op                         r_op1;
    logic                        r_rowend1;
    logic                        r_row_ok1;
    logic                        r_col_ok1;
    logic                        r_yw1;
    logic [PAIR_W-1:0]           r_wpair1;
    logic                        r_ld_odd1;
    logic [WORD_W-1:0]           r_ldv1;
    logic [3:0][VAL_W-1:0]       r_val1;

    logic [WORD_W-1:0]           r_sum_upper;
    logic [WORD_W-1:0]           r_sum_lower;

    logic                        r_ywr2;
    logic                        r_yld2;
    logic [PAIR_W-1:0]           r_wpair2;
    logic                        r_ld_odd2;
    logic [WORD_W-1:0]           r_ldv2;
    logic [WORD_W-1:0]           r_sum2_u;
    logic [WORD_W-1:0]           r_sum2_l;
    logic [WORD_W-1:0]           r_by2_0;
    logic [WORD_W-1:0]           r_by2_1;

    logic                        r_ywr3;
    logic                        r_yld3;
    logic [PAIR_W-1:0]           r_wpair3;
    logic                        r_ld_odd3;
    logic [WORD_W-1:0]           r_ldv3;
    logic [WORD_W-1:0]           r_as3_0;
    logic [WORD_W-1:0]           r_as3_1;
    logic [WORD_W-1:0]           r_by3_0;
    logic [WORD_W-1:0]           r_by3_1;

    // Output register: a y pair sent as two beats.
    logic [1:0]                  r_out_cnt;
    logic [PAIR_W-1:0]           r_opair;
    logic [WORD_W-1:0]           r_oval0;
    logic [WORD_W-1:0]           r_oval1;

    // Memory read data.
    logic [VAL_W-1:0]            x_even_q;
    logic [VAL_W-1:0]            x_odd_q;
    logic [WORD_W-1:0]           y_even_q;
    logic [WORD_W-1:0]           y_odd_q;

    // Input decode and index checks.
    t_op        op_in;
    logic       in_rowend;
    t_pair_chk  row_chk;
    t_pair_chk  col_chk;
    logic       hazard;
    logic       out_free;
    logic       adv;
    logic       accept;
    logic       identity;

    assign op_in     = t_op'(i_in.operation);
    assign in_rowend = (op_in == OP_FINISH) || ((op_in == OP_BLOCK) && i_in.row_last);
    assign row_chk   = pair_check(i_in.block_row, r_index_base, MAX_BLOCK_ROWS);
    assign col_chk   = pair_check(i_in.block_col, r_index_base, MAX_BLOCK_COLS);
    assign identity  = (r_alpha == '0) && (r_beta == WORD_W'(1));

    // A row end reads its y pair at accept, so it must not pass a pending
    // write to the same pair.
    assign hazard = in_rowend && (
                        (r_v1 && r_yw1 && (r_wpair1 == row_chk.pair)) ||
                        ((r_ywr2 || r_yld2) && (r_wpair2 == row_chk.pair)) ||
                        ((r_ywr3 || r_yld3) && (r_wpair3 == row_chk.pair)));

    assign out_free = (r_out_cnt == 2'd0) || ((r_out_cnt == 2'd1) && o_out.ready);
    assign adv      = !r_ywr3 || out_free;
    assign i_in.ready = adv && !hazard;
    assign accept   = i_in.valid && i_in.ready;

    // Stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_yw1 <= 1'b0;
        end else if (adv) begin
            r_v1  <= accept;
            r_yw1 <= accept && ((op_in == OP_LOAD_Y) || (in_rowend && row_chk.ok));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op1     <= op_in;
            r_rowend1 <= in_rowend;
            r_row_ok1 <= row_chk.ok;
            r_col_ok1 <= col_chk.ok;
            r_wpair1  <= (op_in == OP_LOAD_Y) ? i_in.element_index[IDX_W-1:1]
                                              : row_chk.pair;
            r_ld_odd1 <= i_in.element_index[0];
            r_ldv1    <= i_in.load_value;
            r_val1    <= {i_in.val3, i_in.val2, i_in.val1, i_in.val0};
        end
    end

    // Stage 1 logic: block products into the row sums, beta times old y.
    logic signed [2*VAL_W-1:0] p_u0;
    logic signed [2*VAL_W-1:0] p_u1;
    logic signed [2*VAL_W-1:0] p_l0;
    logic signed [2*VAL_W-1:0] p_l1;
    logic [2*VAL_W:0]          s_u;
    logic [2*VAL_W:0]          s_l;
    logic                      add_en;
    logic [WORD_W-1:0]         n_sum_upper;
    logic [WORD_W-1:0]         n_sum_lower;
    logic [WORD_W-1:0]         by0;
    logic [WORD_W-1:0]         by1;

    always_comb begin
        p_u0 = (2*VAL_W)'($signed(r_val1[0])) * (2*VAL_W)'($signed(x_even_q));
        p_l1 = (2*VAL_W)'($signed(r_val1[3])) * (2*VAL_W)'($signed(x_odd_q));
        if (r_direction) begin
            p_u1 = (2*VAL_W)'($signed(r_val1[2])) * (2*VAL_W)'($signed(x_odd_q));
            p_l0 = (2*VAL_W)'($signed(r_val1[1])) * (2*VAL_W)'($signed(x_even_q));
        end else begin
            p_u1 = (2*VAL_W)'($signed(r_val1[1])) * (2*VAL_W)'($signed(x_odd_q));
            p_l0 = (2*VAL_W)'($signed(r_val1[2])) * (2*VAL_W)'($signed(x_even_q));
        end
        s_u    = {p_u0[2*VAL_W-1], p_u0} + {p_u1[2*VAL_W-1], p_u1};
        s_l    = {p_l0[2*VAL_W-1], p_l0} + {p_l1[2*VAL_W-1], p_l1};
        add_en = (r_op1 == OP_BLOCK) && r_col_ok1;
        n_sum_upper = r_sum_upper;
        n_sum_lower = r_sum_lower;
        if (add_en) begin
            n_sum_upper = r_sum_upper + {{(WORD_W-2*VAL_W-1){s_u[2*VAL_W]}}, s_u};
            n_sum_lower = r_sum_lower + {{(WORD_W-2*VAL_W-1){s_l[2*VAL_W]}}, s_l};
        end
        // Beta of zero makes these zero, so unused old y never matters.
        by0 = r_beta * y_even_q;
        by1 = r_beta * y_odd_q;
    end

    // Row sums: cleared at every row end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_upper <= '0;
            r_sum_lower <= '0;
        end else if (adv && r_v1) begin
            if (r_rowend1) begin
                r_sum_upper <= '0;
                r_sum_lower <= '0;
            end else begin
                r_sum_upper <= n_sum_upper;
                r_sum_lower <= n_sum_lower;
            end
        end
    end

    // Stages 2 and 3: alpha times the sums, then the final add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ywr2 <= 1'b0;
            r_yld2 <= 1'b0;
            r_ywr3 <= 1'b0;
            r_yld3 <= 1'b0;
        end else if (adv) begin
            r_ywr2 <= r_v1 && r_rowend1 && r_row_ok1 && !identity;
            r_yld2 <= r_v1 && (r_op1 == OP_LOAD_Y);
            r_ywr3 <= r_ywr2;
            r_yld3 <= r_yld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wpair2  <= r_wpair1;
            r_ld_odd2 <= r_ld_odd1;
            r_ldv2    <= r_ldv1;
            r_sum2_u  <= n_sum_upper;
            r_sum2_l  <= n_sum_lower;
            r_by2_0   <= by0;
            r_by2_1   <= by1;

            r_wpair3  <= r_wpair2;
            r_ld_odd3 <= r_ld_odd2;
            r_ldv3    <= r_ldv2;
            r_as3_0   <= r_alpha * r_sum2_u;
            r_as3_1   <= r_alpha * r_sum2_l;
            r_by3_0   <= r_by2_0;
            r_by3_1   <= r_by2_1;
        end
    end

    logic [WORD_W-1:0] fin0;
    logic [WORD_W-1:0] fin1;

    assign fin0 = r_as3_0 + r_by3_0;
    assign fin1 = r_as3_1 + r_by3_1;

    // Output register and beat sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (adv && r_ywr3) begin
            r_out_cnt <= 2'd2;
        end else if (o_out.valid && o_out.ready) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_ywr3) begin
            r_opair <= r_wpair3;
            r_oval0 <= fin0;
            r_oval1 <= fin1;
        end
    end

    logic lane;

    assign lane          = (r_out_cnt == 2'd1);
    assign o_out.valid   = (r_out_cnt != 2'd0);
    assign o_out.y_index = {r_opair, lane};
    assign o_out.y_value = lane ? r_oval1 : r_oval0;
    assign o_out.last    = lane;

    // x store: written by loads at accept, pair read at accept.
    logic x_we_even;
    logic x_we_odd;

    assign x_we_even = accept && (op_in == OP_LOAD_X) && !i_in.element_index[0];
    assign x_we_odd  = accept && (op_in == OP_LOAD_X) && i_in.element_index[0];

    bsr22_ram #(.WIDTH(VAL_W), .DEPTH(PAIR_DEPTH)) u_x_even (
        .i_clk   (i_clk),
        .i_we    (x_we_even),
        .i_waddr (i_in.element_index[IDX_W-1:1]),
        .i_wdata (i_in.load_value[VAL_W-1:0]),
        .i_re    (accept),
        .i_raddr (col_chk.pair),
        .o_rdata (x_even_q)
    );

    bsr22_ram #(.WIDTH(VAL_W), .DEPTH(PAIR_DEPTH)) u_x_odd (
        .i_clk   (i_clk),
        .i_we    (x_we_odd),
        .i_waddr (i_in.element_index[IDX_W-1:1]),
        .i_wdata (i_in.load_value[VAL_W-1:0]),
        .i_re    (accept),
        .i_raddr (col_chk.pair),
        .o_rdata (x_odd_q)
    );

    // y store: all writes retire in order from the last stage.
    logic              y_we_even;
    logic              y_we_odd;
    logic [WORD_W-1:0] y_wd_even;
    logic [WORD_W-1:0] y_wd_odd;

    assign y_we_even = adv && (r_ywr3 || (r_yld3 && !r_ld_odd3));
    assign y_we_odd  = adv && (r_ywr3 || (r_yld3 && r_ld_odd3));
    assign y_wd_even = r_ywr3 ? fin0 : r_ldv3;
    assign y_wd_odd  = r_ywr3 ? fin1 : r_ldv3;

    bsr22_ram #(.WIDTH(WORD_W), .DEPTH(PAIR_DEPTH)) u_y_even (
        .i_clk   (i_clk),
        .i_we    (y_we_even),
        .i_waddr (r_wpair3),
        .i_wdata (y_wd_even),
        .i_re    (accept),
        .i_raddr (row_chk.pair),
        .o_rdata (y_even_q)
    );

    bsr22_ram #(.WIDTH(WORD_W), .DEPTH(PAIR_DEPTH)) u_y_odd (
        .i_clk   (i_clk),
        .i_we    (y_we_odd),
        .i_waddr (r_wpair3),
        .i_wdata (y_wd_odd),
        .i_re    (accept),
        .i_raddr (row_chk.pair),
        .o_rdata (y_odd_q)
    );

endmodule

FILE: rtl/bsr22_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read.
// No dependencies.
`timescale 1ns / 1ps

module bsr22_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sim/tb_bsr_2x2_spmv_accumulator_top.sv
// Self-checking testbench for bsr_2x2_spmv_accumulator_top: directed and random item streams
// with random idling on both channels, checked beat by beat against a behavioral predictor.
// Depends on bsr22_pkg, the bsr22 channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module tb_bsr_2x2_spmv_accumulator_top;
    import bsr22_pkg::*;

    typedef struct {
        t_op               op;
        logic [IDX_W-1:0]  elem;
        logic [WORD_W-1:0] load_value;
        logic [IDX_W-1:0]  brow;
        logic [IDX_W-1:0]  bcol;
        logic [VAL_W-1:0]  v0;
        logic [VAL_W-1:0]  v1;
        logic [VAL_W-1:0]  v2;
        logic [VAL_W-1:0]  v3;
        logic              row_last;
    } t_item;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] value;
        logic              last;
    } t_ybeat;

    logic i_clk;
    logic i_rst_n;

    bsr22_cfg_if cfg_ch ();
    bsr22_in_if  in_ch ();
    bsr22_out_if out_ch ();

    bsr_2x2_spmv_accumulator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted block state and register copies.
    logic [VAL_W-1:0]  x_mem [STORE_DEPTH];
    logic [WORD_W-1:0] y_mem [STORE_DEPTH];
    bit                x_written [STORE_DEPTH];
    bit                y_written [STORE_DEPTH];
    logic [WORD_W-1:0] sum_upper = '0;
    logic [WORD_W-1:0] sum_lower = '0;
    logic [WORD_W-1:0] cfg_alpha = 32'd1;
    logic [WORD_W-1:0] cfg_beta  = 32'd0;
    logic              cfg_dir   = 1'b0;
    logic              cfg_base  = 1'b0;

    // Y writes predicted but not yet seen on the output.
    t_ybeat y_writes_due [$];

    int  items_sent    = 0;
    int  checked_beats = 0;
    int  cfg_writes    = 0;
    int  mismatches    = 0;
    int  in_idle_pct   = 0;
    int  out_idle_pct  = 0;
    bit  hold_req      = 1'b0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #4_800_000;
        $display("tb_bsr_2x2_spmv_accumulator_top NOT OK");
        $finish;
    end

    function automatic logic [WORD_W-1:0] sx8(logic [VAL_W-1:0] b);
        return {{(WORD_W-VAL_W){b[VAL_W-1]}}, b};
    endfunction

    // Ends a block row: scales the sums, merges old y and queues the two y beats.
    task automatic retire_row(logic [IDX_W-1:0] raw);
        int                idx;
        logic [WORD_W-1:0] s [2];
        t_ybeat            b;
        logic [IDX_W-1:0]  a;
        idx       = int'(raw) - int'(cfg_base);
        s[0]      = sum_upper;
        s[1]      = sum_lower;
        sum_upper = '0;
        sum_lower = '0;
        if (idx < 0 || idx >= MAX_BLOCK_ROWS)
            return;
        if (cfg_alpha == 32'd0 && cfg_beta == 32'd1)
            return;
        for (int k = 0; k < 2; k++) begin
            a       = IDX_W'(idx * 2 + k);
            b.value = cfg_alpha * s[k];
            if (cfg_beta != 32'd0)
                b.value = b.value + cfg_beta * y_mem[a];
            y_mem[a] = b.value;
            b.idx    = a;
            b.last   = k[0];
            y_writes_due.push_back(b);
        end
    endtask

    // Updates the predicted state for one accepted item.
    task automatic apply_item(t_item it);
        int                col;
        logic [WORD_W-1:0] x0;
        logic [WORD_W-1:0] x1;
        case (it.op)
            OP_LOAD_X: begin
                x_mem[it.elem]     = it.load_value[VAL_W-1:0];
                x_written[it.elem] = 1'b1;
            end
            OP_LOAD_Y: begin
                y_mem[it.elem]     = it.load_value;
                y_written[it.elem] = 1'b1;
            end
            OP_FINISH: begin
                retire_row(it.brow);
            end
            default: begin
                col = int'(it.bcol) - int'(cfg_base);
                if (col >= 0 && col < MAX_BLOCK_COLS) begin
                    x0 = sx8(x_mem[col * 2]);
                    x1 = sx8(x_mem[col * 2 + 1]);
                    if (cfg_dir) begin
                        sum_upper = sum_upper + sx8(it.v0) * x0 + sx8(it.v2) * x1;
                        sum_lower = sum_lower + sx8(it.v1) * x0 + sx8(it.v3) * x1;
                    end else begin
                        sum_upper = sum_upper + sx8(it.v0) * x0 + sx8(it.v1) * x1;
                        sum_lower = sum_lower + sx8(it.v2) * x0 + sx8(it.v3) * x1;
                    end
                end
                if (it.row_last)
                    retire_row(it.brow);
            end
        endcase
    endtask

    // Pair that a raw block index lands on after base removal, wrapped to the store.
    function automatic logic [PAIR_W-1:0] wrapped_pair(logic [IDX_W-1:0] raw);
        logic [IDX_W-1:0] t;
        t = raw - IDX_W'(cfg_base);
        return t[PAIR_W-1:0];
    endfunction

    function automatic bit pair_loaded(logic [PAIR_W-1:0] p);
        return x_written[{p, 1'b0}] && x_written[{p, 1'b1}]
            && y_written[{p, 1'b0}] && y_written[{p, 1'b1}];
    endfunction

    // Block index for a load beat: random where its pair is loaded, else pair zero.
    function automatic logic [IDX_W-1:0] safe_raw();
        logic [IDX_W-1:0] r;
        r = IDX_W'($urandom);
        if (pair_loaded(wrapped_pair(r)))
            return r;
        return IDX_W'(cfg_base);
    endfunction

    function automatic t_item mk_load(t_op op, logic [IDX_W-1:0] addr, logic [WORD_W-1:0] value);
        t_item it;
        it.op         = op;
        it.elem       = addr;
        it.load_value = value;
        it.brow       = safe_raw();
        it.bcol       = safe_raw();
        it.v0         = VAL_W'($urandom);
        it.v1         = VAL_W'($urandom);
        it.v2         = VAL_W'($urandom);
        it.v3         = VAL_W'($urandom);
        it.row_last   = 1'($urandom);
        return it;
    endfunction

    function automatic t_item mk_block(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                       logic [VAL_W-1:0] v0, logic [VAL_W-1:0] v1,
                                       logic [VAL_W-1:0] v2, logic [VAL_W-1:0] v3,
                                       logic last);
        t_item it;
        it.op         = OP_BLOCK;
        it.elem       = IDX_W'($urandom);
        it.load_value = $urandom;
        it.brow       = row;
        it.bcol       = col;
        it.v0         = v0;
        it.v1         = v1;
        it.v2         = v2;
        it.v3         = v3;
        it.row_last   = last;
        return it;
    endfunction

    // Finish beats carry random value fields and row_last, which the block ignores.
    function automatic t_item mk_finish(logic [IDX_W-1:0] row);
        t_item it;
        it    = mk_block(row, IDX_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                         VAL_W'($urandom), VAL_W'($urandom), 1'($urandom));
        it.op = OP_FINISH;
        return it;
    endfunction

    function automatic logic [IDX_W-1:0] pick_raw(int spread);
        if ($urandom_range(0, 99) < 88)
            return IDX_W'(int'(cfg_base) + $urandom_range(0, spread));
        return IDX_W'($urandom_range(0, STORE_DEPTH - 1));
    endfunction

    // Sends one input beat, with an optional idle burst in front of it.
    task automatic send_item(t_item it);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        @(negedge i_clk);
        in_ch.operation     <= it.op;
        in_ch.element_index <= it.elem;
        in_ch.load_value    <= it.load_value;
        in_ch.block_row     <= it.brow;
        in_ch.block_col     <= it.bcol;
        in_ch.val0          <= it.v0;
        in_ch.val1          <= it.v1;
        in_ch.val2          <= it.v2;
        in_ch.val3          <= it.v3;
        in_ch.row_last      <= it.row_last;
        in_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_item(it);
        items_sent++;
    endtask

    // Loads any x or y element that a block or finish beat could read before sending it.
    task automatic issue(t_item it);
        logic [PAIR_W-1:0] pr;
        logic [PAIR_W-1:0] pc;
        if (it.op == OP_BLOCK || it.op == OP_FINISH) begin
            pr = wrapped_pair(it.brow);
            pc = wrapped_pair(it.bcol);
            for (int k = 0; k < 2; k++) begin
                if (!x_written[{pc, k[0]}])
                    send_item(mk_load(OP_LOAD_X, {pc, k[0]}, $urandom));
                if (!y_written[{pr, k[0]}])
                    send_item(mk_load(OP_LOAD_Y, {pr, k[0]}, $urandom));
            end
        end
        send_item(it);
    endtask

    // Drops valid, waits for every predicted beat, then lets the pipeline drain.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (y_writes_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg r, logic [WORD_W-1:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (r)
            CFG_ALPHA:     cfg_alpha = d;
            CFG_BETA:      cfg_beta  = d;
            CFG_DIRECTION: cfg_dir   = d[0];
            default:       cfg_base  = d[0];
        endcase
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic dir,
                              logic base);
        settle();
        cfg_write(CFG_ALPHA, a);
        cfg_write(CFG_BETA, b);
        cfg_write(CFG_DIRECTION, {31'($urandom), dir});
        cfg_write(CFG_INDEX_BASE, {31'($urandom), base});
    endtask

    // Random stream: mostly well-formed block rows, plus loads and noise beats.
    task automatic run_random(int goal, int spread);
        int               kind;
        int               nblk;
        logic [IDX_W-1:0] row;
        t_item            it;
        while (items_sent < goal) begin
            kind = $urandom_range(0, 99);
            row  = pick_raw(spread);
            if (kind < 70) begin
                nblk = $urandom_range(1, 4);
                for (int j = 0; j < nblk; j++)
                    issue(mk_block(row, pick_raw(spread), VAL_W'($urandom), VAL_W'($urandom),
                                   VAL_W'($urandom), VAL_W'($urandom),
                                   (j == nblk - 1) && (kind >= 7)));
                // Some rows are closed by an explicit finish instead of row_last.
                if (kind < 7)
                    issue(mk_finish(row));
            end else if (kind < 80) begin
                issue(mk_finish(row));
            end else if (kind < 90) begin
                issue(mk_load(kind[0] ? OP_LOAD_Y : OP_LOAD_X, IDX_W'($urandom), $urandom));
            end else begin
                it = mk_block(IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom),
                              VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                              1'($urandom));
                if ($urandom_range(0, 1))
                    it.op = OP_FINISH;
                issue(it);
            end
        end
    endtask

    // Reset settings: extreme loads, full-scale values, empty rows, out-of-range indices.
    task automatic test_reset_defaults();
        in_idle_pct  = 10;
        out_idle_pct = 10;
        issue(mk_load(OP_LOAD_X, 10'd0, 32'h0000_007F));
        issue(mk_load(OP_LOAD_X, 10'd1, 32'hFFFF_FF80));
        issue(mk_load(OP_LOAD_X, 10'd1022, 32'h7FFF_FFFF));
        issue(mk_load(OP_LOAD_X, 10'd1023, 32'h8000_0000));
        issue(mk_load(OP_LOAD_Y, 10'd0, 32'h7FFF_FFFF));
        issue(mk_load(OP_LOAD_Y, 10'd1, 32'h8000_0000));
        issue(mk_load(OP_LOAD_Y, 10'd1022, 32'hFFFF_FFFF));
        issue(mk_load(OP_LOAD_Y, 10'd1023, 32'h0000_0000));
        issue(mk_block(10'd0, 10'd0, 8'h7F, 8'h80, 8'h80, 8'h7F, 1'b0));
        issue(mk_block(10'd0, 10'd511, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1));
        issue(mk_finish(10'd511));
        issue(mk_block(10'd0, 10'd512, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1));
        issue(mk_block(10'd700, 10'd0, 8'h11, 8'h22, 8'h33, 8'h44, 1'b1));
        issue(mk_block(10'd1, 10'd1023, 8'hFF, 8'h01, 8'hFF, 8'h01, 1'b1));
        issue(mk_finish(10'd1023));
    endtask

    // Extreme scales, column-major order, one-based indices and identity scaling.
    task automatic test_config_extremes();
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        issue(mk_block(10'd1, 10'd1, 8'h7F, 8'h80, 8'h01, 8'hFF, 1'b0));
        issue(mk_block(10'd512, 10'd512, 8'h80, 8'h7F, 8'h7F, 8'h80, 1'b1));
        issue(mk_block(10'd0, 10'd0, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1));
        issue(mk_block(10'd513, 10'd1, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
        issue(mk_block(10'd2, 10'd513, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0));
        issue(mk_finish(10'd1));
        set_config(32'd0, 32'd1, 1'b0, 1'b0);
        issue(mk_block(10'd0, 10'd0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1));
        issue(mk_finish(10'd3));
        set_config(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        issue(mk_finish(10'd0));
    endtask

    // Several register settings in turn, the extremes among them.
    task automatic test_random_sweep();
        logic [WORD_W-1:0] alphas [8];
        logic [WORD_W-1:0] betas  [8];
        int                pcts   [3];
        alphas = '{32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                   32'hFFFF_FFFF, 32'd0, 32'd0, 32'd3};
        betas  = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
                   32'd1, 32'd0, 32'd0, 32'd0};
        pcts   = '{0, 10, 35};
        alphas[5] = $urandom;
        betas[5]  = $urandom;
        alphas[6] = $urandom;
        betas[6]  = $urandom;
        betas[7]  = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            set_config(alphas[ph], betas[ph], ph[0], ph[1]);
            in_idle_pct  = pcts[$urandom_range(0, 2)];
            out_idle_pct = pcts[$urandom_range(0, 2)];
            run_random(items_sent + 175, (ph == 6) ? 511 : 15);
        end
    endtask

    // Output held off for a long stretch while row ends keep arriving.
    task automatic test_backpressure();
        set_config($urandom, $urandom, 1'($urandom), 1'($urandom));
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_req     = 1'b1;
        for (int n = 0; n < 48; n++)
            issue(mk_block(pick_raw(7), pick_raw(7), VAL_W'($urandom), VAL_W'($urandom),
                           VAL_W'($urandom), VAL_W'($urandom), 1'b1));
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        set_config($urandom, $urandom, 1'($urandom), 1'($urandom));
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(items_sent + 200, 15);
    endtask

    // Output ready: random stall bursts, plus one long hold on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (239) @(negedge i_clk);
            end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: each accepted beat against the oldest predicted y write.
    initial begin
        t_ybeat exp_b;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (y_writes_due.size() == 0) begin
                    $error("unexpected y beat: index %0d value %0h", out_ch.y_index,
                           out_ch.y_value);
                    mismatches++;
                end else begin
                    exp_b = y_writes_due.pop_front();
                    checked_beats++;
                    if (out_ch.y_index !== exp_b.idx) begin
                        $error("y_index: expected %0d, actual %0d", exp_b.idx, out_ch.y_index);
                        mismatches++;
                    end
                    if (out_ch.y_value !== exp_b.value) begin
                        $error("y_value: expected %0h, actual %0h", exp_b.value,
                               out_ch.y_value);
                        mismatches++;
                    end
                    if (out_ch.last !== exp_b.last) begin
                        $error("last: expected %0b, actual %0b", exp_b.last, out_ch.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Reset, test sequence and verdict.
    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = OP_LOAD_X;
        in_ch.element_index = '0;
        in_ch.load_value    = '0;
        in_ch.block_row     = '0;
        in_ch.block_col     = '0;
        in_ch.val0          = '0;
        in_ch.val1          = '0;
        in_ch.val2          = '0;
        in_ch.val3          = '0;
        in_ch.row_last      = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_ALPHA;
        cfg_ch.data         = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_random_sweep();
        test_backpressure();
        test_full_rate();
        settle();

        $display("Sent %0d input items over %0d register writes; checked %0d y beats.",
                 items_sent, cfg_writes, checked_beats);
        if (mismatches == 0 && y_writes_due.size() == 0)
            $display("tb_bsr_2x2_spmv_accumulator_top OK");
        else
            $display("tb_bsr_2x2_spmv_accumulator_top NOT OK");
        $finish;
    end

endmodule
